// ===== rtl/vzc_pkg.sv =====
// Shared types, constants and zigzag helpers for the varint codec.
package vzc_pkg;

    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned NARROW_W  = 32;
    localparam int unsigned GROUP_W   = 7;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned GROUPS    = 10;

    localparam logic [COUNT_W-1:0] NARROW_LIMIT = 4'd5;
    localparam logic [COUNT_W-1:0] WIDE_LIMIT   = 4'd10;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // Register indexes as seen on paddr[3:2].
    typedef enum logic [1:0] {
        REG_DIRECTION = 2'd0,
        REG_WIDE_MODE = 2'd1,
        REG_ZIGZAG_ON = 2'd2
    } reg_index_t;

    // Configuration as seen by the encoder and the decoder.
    typedef struct packed {
        logic direction;
        logic wide_mode;
        logic zigzag_on;
    } cfg_t;

    // Encoder state toward the output register.
    typedef struct packed {
        logic              busy;
        logic              last;
        logic [BYTE_W-1:0] data;
    } enc_status_t;

    // Decoder completion toward the output register.
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] value;
    } dec_status_t;

    function automatic logic [VALUE_W-1:0] width_mask(input logic wide);
        logic [VALUE_W-1:0] m;
        m = wide ? {VALUE_W{1'b1}} : {{(VALUE_W-NARROW_W){1'b0}}, {NARROW_W{1'b1}}};
        return m;
    endfunction

    // Zigzag mapping: (n << 1) ^ (n >> (w-1)), held to the width.
    function automatic logic [VALUE_W-1:0] zz_encode(input logic [VALUE_W-1:0] v,
                                                     input logic wide);
        logic sign;
        sign = wide ? v[VALUE_W-1] : v[NARROW_W-1];
        return ({v[VALUE_W-2:0], 1'b0} ^ {VALUE_W{sign}}) & width_mask(wide);
    endfunction

    // Inverse zigzag mapping: (v >> 1) ^ -(v & 1), held to the width.
    function automatic logic [VALUE_W-1:0] zz_decode(input logic [VALUE_W-1:0] v,
                                                     input logic wide);
        logic [VALUE_W-1:0] m;
        m = v & width_mask(wide);
        return ({1'b0, m[VALUE_W-1:1]} ^ {VALUE_W{m[0]}}) & width_mask(wide);
    endfunction

endpackage

// ===== rtl/vzc_encoder.sv =====
// Encoder: value shifter that emits one 7-bit group per byte.
module vzc_encoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  vzc_pkg::cfg_t                       cfg,
    input  logic                                load,
    input  logic [vzc_pkg::VALUE_W-1:0]         value_in,
    input  logic                                step,
    output vzc_pkg::enc_status_t                status
);
    import vzc_pkg::*;

    logic [VALUE_W-1:0] shift_reg, shift_next;
    logic               busy_reg, busy_next;
    logic [VALUE_W-1:0] mapped;
    logic               final_group;

    // The current group is the final one when nothing lies above it.
    assign final_group = ~|shift_reg[VALUE_W-1:GROUP_W];

    // Width mask and optional zigzag mapping of a new value.
    always_comb begin
        mapped = value_in & width_mask(cfg.wide_mode);
        if (cfg.zigzag_on) begin
            mapped = zz_encode(mapped, cfg.wide_mode);
        end
    end

    // A new value takes priority; otherwise each step drops one group.
    always_comb begin
        shift_next = shift_reg;
        busy_next  = busy_reg;
        if (load) begin
            shift_next = mapped;
            busy_next  = 1'b1;
        end else if (step && busy_reg) begin
            shift_next = {{GROUP_W{1'b0}}, shift_reg[VALUE_W-1:GROUP_W]};
            if (final_group) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

    assign status.busy = busy_reg;
    assign status.last = final_group;
    assign status.data = {~final_group, shift_reg[GROUP_W-1:0]};

endmodule

// ===== rtl/vzc_decoder.sv =====
// Decoder: gathers 7-bit groups into the accumulator, one byte per request.
module vzc_decoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  vzc_pkg::cfg_t                cfg,
    input  logic                         take,
    input  logic [vzc_pkg::BYTE_W-1:0]   in_byte,
    output vzc_pkg::dec_status_t         status
);
    import vzc_pkg::*;

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [VALUE_W-1:0] merged;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] limit;
    logic [VALUE_W-1:0] result;

    // Place the group at the slot selected by the byte count.
    always_comb begin
        merged = acc_reg;
        for (int k = 0; k < GROUPS - 1; k++) begin
            if (count_reg == COUNT_W'(k)) begin
                merged[k*GROUP_W +: GROUP_W] = acc_reg[k*GROUP_W +: GROUP_W]
                                             | in_byte[GROUP_W-1:0];
            end
        end
        // The tenth group keeps only its lowest bit; the rest is beyond the width.
        if (count_reg == COUNT_W'(GROUPS - 1)) begin
            merged[VALUE_W-1] = acc_reg[VALUE_W-1] | in_byte[0];
        end
    end

    assign count_inc = count_reg + 1'b1;
    assign limit     = cfg.wide_mode ? WIDE_LIMIT : NARROW_LIMIT;

    // A value completes on a final byte or at the width's byte limit.
    assign status.done = !in_byte[BYTE_W-1] || (count_inc >= limit);

    always_comb begin
        result = merged & width_mask(cfg.wide_mode);
        if (cfg.zigzag_on) begin
            result = zz_decode(result, cfg.wide_mode);
        end
    end
    assign status.value = result;

    // Completion clears the accumulator and the count.
    always_comb begin
        acc_next   = acc_reg;
        count_next = count_reg;
        if (take) begin
            if (status.done) begin
                acc_next   = '0;
                count_next = '0;
            end else begin
                acc_next   = merged;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            count_reg <= '0;
        end else begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/varint_zigzag_codec.sv =====
// Top level of the base-128 varint codec with optional zigzag mapping.
// Encode (direction 0): each accepted value yields 1 to 5 bytes (32-bit
// mode) or 1 to 10 bytes (64-bit mode); the encoder's value shifter emits
// one 7-bit group per cycle while the output is free, the next value is
// taken in the cycle its last byte leaves, and each value is held in the
// value shifter and its bytes in the output register. Decode (direction 1):
// one byte is taken per cycle while the output is free and the encoder
// idle; a completed value is registered in the cycle after its final byte.
// Results carry tuser flags; tlast marks the final result of each request.
// Registers are to be written over the APB port while the block is idle,
// not enforced by the block; direction at 0x0, wide_mode at 0x4, zigzag_on at 0x8.
module varint_zigzag_codec (
    input  logic                         aclk,
    input  logic                         aresetn,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vzc_pkg::ADDR_W-1:0]   paddr,
    input  logic [vzc_pkg::DATA_W-1:0]   pwdata,
    output logic [vzc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // Input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [71:0]                  s_tdata,   // value_in[63:0], in_byte[71:64]
    // Output stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [71:0]                  m_tdata,   // out_byte[7:0], value_out[71:8]
    output logic [1:0]                   m_tuser,   // byte_valid[0], value_valid[1]
    output logic                         m_tlast
);
    import vzc_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    enc_status_t enc_st;
    dec_status_t dec_st;

    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [VALUE_W-1:0] value_out_reg, value_out_next;
    logic              byte_valid_reg, byte_valid_next;
    logic              value_valid_reg, value_valid_next;
    logic              last_reg, last_next;

    logic        cfg_write;
    reg_index_t  cfg_index;
    logic        out_free;
    logic        s_accept;
    logic        enc_load;
    logic        enc_emit;
    logic        dec_take;

    // Register port: always ready, written in the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                REG_DIRECTION: cfg_next.direction = pwdata[0];
                REG_WIDE_MODE: cfg_next.wide_mode = pwdata[0];
                REG_ZIGZAG_ON: cfg_next.zigzag_on = pwdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_DIRECTION: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.direction};
            REG_WIDE_MODE: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.wide_mode};
            REG_ZIGZAG_ON: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.zigzag_on};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{direction: 1'b0, wide_mode: 1'b1, zigzag_on: 1'b0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Handshake: the output register frees when empty or being taken.
    assign out_free = !m_valid_reg || m_tready;
    assign enc_emit = enc_st.busy && out_free;
    assign s_tready = cfg_reg.direction ? (out_free && !enc_st.busy)
                                        : (!enc_st.busy || (out_free && enc_st.last));
    assign s_accept = s_tvalid && s_tready;
    assign enc_load = s_accept && !cfg_reg.direction;
    assign dec_take = s_accept && cfg_reg.direction;

    vzc_encoder u_encoder (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .load     (enc_load),
        .value_in (s_tdata[VALUE_W-1:0]),
        .step     (enc_emit),
        .status   (enc_st)
    );

    vzc_decoder u_decoder (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .take     (dec_take),
        .in_byte  (s_tdata[VALUE_W +: BYTE_W]),
        .status   (dec_st)
    );

    // Output register, loaded by the encoder or by a completed decode.
    always_comb begin
        m_valid_next     = m_valid_reg;
        out_byte_next    = out_byte_reg;
        value_out_next   = value_out_reg;
        byte_valid_next  = byte_valid_reg;
        value_valid_next = value_valid_reg;
        last_next        = last_reg;
        if (enc_emit) begin
            m_valid_next     = 1'b1;
            out_byte_next    = enc_st.data;
            value_out_next   = '0;
            byte_valid_next  = 1'b1;
            value_valid_next = 1'b0;
            last_next        = enc_st.last;
        end else if (dec_take && dec_st.done) begin
            m_valid_next     = 1'b1;
            out_byte_next    = '0;
            value_out_next   = dec_st.value;
            byte_valid_next  = 1'b0;
            value_valid_next = 1'b1;
            last_next        = 1'b1;
        end else if (m_tready) begin
            m_valid_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg    <= out_byte_next;
        value_out_reg   <= value_out_next;
        byte_valid_reg  <= byte_valid_next;
        value_valid_reg <= value_valid_next;
        last_reg        <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {value_out_reg, out_byte_reg};
    assign m_tuser  = {value_valid_reg, byte_valid_reg};
    assign m_tlast  = last_reg;

    // A decode request is never taken while the encoder still holds a value.
    a_decode_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_take |-> !enc_st.busy)
        else $error("decode request taken while encoder busy");

    // The encoder goes idle after its final byte unless a new value came in.
    a_encoder_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (enc_emit && enc_st.last && !enc_load) |=> !enc_st.busy)
        else $error("encoder still busy after its final byte");

    // A valid result carries exactly one kind of payload.
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (byte_valid_reg ^ value_valid_reg))
        else $error("result carries no kind or both kinds");

    // A decoded value is always the final result of its request.
    a_value_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && value_valid_reg) |-> last_reg)
        else $error("decoded value without last");

endmodule
